[rtl/core/qmalu_pkg.sv]
// ----------------------------------------------------------------------------
// qmalu_pkg
// Shared widths, instruction codes and status codes for the queue-machine ALU.
// ----------------------------------------------------------------------------
package qmalu_pkg;

  localparam int WORD_W  = 16;
  localparam int OP_W    = 3;
  localparam int FILL_W  = 11;
  localparam int STAT_W  = 2;
  localparam int DCNT_W  = $clog2(WORD_W + 1);

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [OP_W-1:0]   op_t;
  typedef logic [FILL_W-1:0] fill_t;
  typedef logic [STAT_W-1:0] stat_t;

  localparam op_t OP_PUSH = 3'd0;
  localparam op_t OP_ADD  = 3'd1;
  localparam op_t OP_SUB  = 3'd2;
  localparam op_t OP_MUL  = 3'd3;
  localparam op_t OP_DIV  = 3'd4;
  localparam op_t OP_MOD  = 3'd5;

  localparam stat_t ST_OK    = 2'd0;
  localparam stat_t ST_UNDER = 2'd1;
  localparam stat_t ST_OVER  = 2'd2;

endpackage

[rtl/core/qmalu_queue_mem.sv]
// ----------------------------------------------------------------------------
// qmalu_queue_mem
// Queue storage: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module qmalu_queue_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [AW-1:0]         waddr,
  input  qmalu_pkg::word_t      wdata,
  input  logic [AW-1:0]         raddr,
  output qmalu_pkg::word_t      rdata
);
  import qmalu_pkg::*;

  word_t mem [DEPTH];
  word_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/core/qmalu_divider.sv]
// ----------------------------------------------------------------------------
// qmalu_divider
// Restoring divider, one quotient bit per cycle; done pulses for one cycle.
// ----------------------------------------------------------------------------
module qmalu_divider (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  qmalu_pkg::word_t dividend,
  input  qmalu_pkg::word_t divisor,
  output logic             done,
  output qmalu_pkg::word_t quotient,
  output qmalu_pkg::word_t remainder
);
  import qmalu_pkg::*;

  word_t             rem_r, rem_nxt;
  word_t             quo_r, quo_nxt;
  word_t             dsr_r, dsr_nxt;
  logic [DCNT_W-1:0] cnt_r, cnt_nxt;
  logic              run_r, run_nxt;
  logic              done_r, done_nxt;
  logic [WORD_W:0]   shifted;
  logic [WORD_W:0]   trial;

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    shifted  = {rem_r, quo_r[WORD_W-1]};
    trial    = shifted - {1'b0, dsr_r};
    if (start) begin
      rem_nxt = '0;
      quo_nxt = dividend;
      dsr_nxt = divisor;
      cnt_nxt = DCNT_W'(WORD_W);
      run_nxt = 1'b1;
    end else if (run_r) begin
      // take one quotient bit; restore when the trial goes negative
      if (trial[WORD_W]) begin
        rem_nxt = shifted[WORD_W-1:0];
        quo_nxt = {quo_r[WORD_W-2:0], 1'b0};
      end else begin
        rem_nxt = trial[WORD_W-1:0];
        quo_nxt = {quo_r[WORD_W-2:0], 1'b1};
      end
      cnt_nxt = cnt_r - DCNT_W'(1);
      if (cnt_r == DCNT_W'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dsr_r <= dsr_nxt;
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

[rtl/core/queue_machine_alu_unit.sv]
// ----------------------------------------------------------------------------
// queue_machine_alu_unit
// Queue-machine interpreter: push and arithmetic on a FIFO of 16-bit words.
// ----------------------------------------------------------------------------
// Usage:
//   Drive in_operation / in_push_value and raise start; the instruction is
//   taken on a clock edge where start is high and busy is low.
//   Each instruction gives exactly one result word, shown for one cycle with
//   out_strobe high: out_result_value, out_fill_count and out_status.
//   The receiver cannot stall; a result is taken in the cycle it is shown.
// Latency and throughput:
//   push, unused codes and errors: result in the cycle after acceptance,
//     busy stays low, so one instruction per cycle.
//   add, subtract, multiply: busy through two dependent reads of the queue
//     memory (S_RDB, S_CAPB), then S_EXEC computes and writes back.
//   divide, modulo: as above, but S_EXEC starts the bit-serial divider
//     (16 steps) and S_DIV waits for it, then writes back.
//   A new instruction may be accepted in the cycle its predecessor's
//   result is shown.
// Reset (rst_n low, synchronous): head, tail and fill count go to zero and
//   the sequencer returns to idle. Queue memory is not cleared: only
//   written entries are ever read.
// ----------------------------------------------------------------------------
module queue_machine_alu_unit #(
  parameter int QUEUE_DEPTH = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  qmalu_pkg::op_t    in_operation,
  input  qmalu_pkg::word_t  in_push_value,
  output logic              out_strobe,
  output qmalu_pkg::word_t  out_result_value,
  output qmalu_pkg::fill_t  out_fill_count,
  output qmalu_pkg::stat_t  out_status
);
  import qmalu_pkg::*;

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  // sequencer codes
  localparam logic [2:0] S_IDLE = 3'd0;  // decode, push, report errors
  localparam logic [2:0] S_RDB  = 3'd1;  // capture first operand, read second
  localparam logic [2:0] S_CAPB = 3'd2;  // capture second operand
  localparam logic [2:0] S_EXEC = 3'd3;  // compute and write back, or start divide
  localparam logic [2:0] S_DIV  = 3'd4;  // wait for the divider, then write back

  logic [2:0]    state_r, state_nxt;
  op_t           op_r, op_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic [AW-1:0] tail_r, tail_nxt;
  logic [CW-1:0] count_r, count_nxt;
  word_t         opa_r, opa_nxt;
  word_t         opb_r, opb_nxt;

  logic          strobe_r, strobe_nxt;
  word_t         res_out_r, res_out_nxt;
  fill_t         fill_out_r, fill_out_nxt;
  stat_t         stat_out_r, stat_out_nxt;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  word_t         mem_wdata;
  logic [AW-1:0] mem_raddr;
  word_t         mem_rdata;

  logic          div_start;
  logic          div_done;
  word_t         div_quo;
  word_t         div_rem;

  logic [AW-1:0] head_p1;
  logic [AW-1:0] head_p2;
  logic [AW-1:0] tail_p1;
  logic [2*WORD_W-1:0] product;
  word_t         alu_res;
  logic          full;
  logic          few;

  function automatic logic [AW-1:0] next_pos(input logic [AW-1:0] p);
    if (p == AW'(QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + AW'(1);
  endfunction

  // fill count reported modulo 2048
  function automatic fill_t to_fill(input logic [CW-1:0] c);
    logic [31:0] wide;
    wide = 32'(c);
    return wide[FILL_W-1:0];
  endfunction

  assign head_p1 = next_pos(head_r);
  assign head_p2 = next_pos(head_p1);
  assign tail_p1 = next_pos(tail_r);
  assign full    = (count_r == CW'(QUEUE_DEPTH));
  assign few     = (count_r < CW'(2));
  assign product = (2*WORD_W)'(opa_r) * (2*WORD_W)'(opb_r);

  always_comb begin
    case (op_r)
      OP_ADD:  alu_res = opa_r + opb_r;
      OP_SUB:  alu_res = opa_r - opb_r;
      OP_MUL:  alu_res = product[WORD_W-1:0];
      OP_DIV:  alu_res = (opb_r == '0) ? '0 : div_quo;
      OP_MOD:  alu_res = (opb_r == '0) ? '0 : div_rem;
      default: alu_res = '0;
    endcase
  end

  always_comb begin
    state_nxt    = state_r;
    op_nxt       = op_r;
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    count_nxt    = count_r;
    opa_nxt      = opa_r;
    opb_nxt      = opb_r;
    strobe_nxt   = 1'b0;
    res_out_nxt  = res_out_r;
    fill_out_nxt = fill_out_r;
    stat_out_nxt = stat_out_r;
    mem_we       = 1'b0;
    mem_waddr    = tail_r;
    mem_wdata    = in_push_value;
    mem_raddr    = head_r;
    div_start    = 1'b0;

    case (state_r)
      S_IDLE: begin
        // the head read is issued every idle cycle; it is only used when
        // an arithmetic instruction is accepted
        if (start) begin
          op_nxt = in_operation;
          case (in_operation)
            OP_PUSH: begin
              strobe_nxt = 1'b1;
              if (full) begin
                // drop the word, flag overflow
                res_out_nxt  = '0;
                fill_out_nxt = to_fill(count_r);
                stat_out_nxt = ST_OVER;
              end else begin
                mem_we       = 1'b1;
                tail_nxt     = tail_p1;
                count_nxt    = count_r + CW'(1);
                res_out_nxt  = in_push_value;
                fill_out_nxt = to_fill(count_r + CW'(1));
                stat_out_nxt = ST_OK;
              end
            end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD: begin
              if (few) begin
                strobe_nxt   = 1'b1;
                res_out_nxt  = '0;
                fill_out_nxt = to_fill(count_r);
                stat_out_nxt = ST_UNDER;
              end else begin
                state_nxt = S_RDB;
              end
            end
            default: begin
              // unused code: no operation
              strobe_nxt   = 1'b1;
              res_out_nxt  = '0;
              fill_out_nxt = to_fill(count_r);
              stat_out_nxt = ST_OK;
            end
          endcase
        end
      end
      S_RDB: begin
        opa_nxt   = mem_rdata;
        mem_raddr = head_p1;
        state_nxt = S_CAPB;
      end
      S_CAPB: begin
        opb_nxt   = mem_rdata;
        state_nxt = S_EXEC;
      end
      S_EXEC, S_DIV: begin
        if (state_r == S_EXEC && (op_r inside {OP_DIV, OP_MOD})) begin
          div_start = 1'b1;
          state_nxt = S_DIV;
        end else if (state_r == S_EXEC || div_done) begin
          // write back: two out, one in
          mem_we       = 1'b1;
          mem_wdata    = alu_res;
          tail_nxt     = tail_p1;
          head_nxt     = head_p2;
          count_nxt    = count_r - CW'(1);
          strobe_nxt   = 1'b1;
          res_out_nxt  = alu_res;
          fill_out_nxt = to_fill(count_r - CW'(1));
          stat_out_nxt = ST_OK;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Writes land only at the end of an instruction and reads start at the
  // earliest in the following cycle, so the sequence itself interlocks the
  // memory: no forwarding path is needed.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      head_r   <= '0;
      tail_r   <= '0;
      count_r  <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      head_r   <= head_nxt;
      tail_r   <= tail_nxt;
      count_r  <= count_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    opa_r      <= opa_nxt;
    opb_r      <= opb_nxt;
    res_out_r  <= res_out_nxt;
    fill_out_r <= fill_out_nxt;
    stat_out_r <= stat_out_nxt;
  end

  qmalu_queue_mem #(
    .DEPTH (QUEUE_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  qmalu_divider u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (opa_r),
    .divisor   (opb_r),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  assign busy             = (state_r != S_IDLE);
  assign out_strobe       = strobe_r;
  assign out_result_value = res_out_r;
  assign out_fill_count   = fill_out_r;
  assign out_status       = stat_out_r;

endmodule

[rtl/core/qmalu_checker.sv]
// ----------------------------------------------------------------------------
// qmalu_checker
// Port-level checks on the queue-machine ALU, bound to the top level.
// ----------------------------------------------------------------------------
module qmalu_checker (
  input logic             clk,
  input logic             rst_n,
  input logic             start,
  input logic             busy,
  input qmalu_pkg::op_t   in_operation,
  input logic             out_strobe,
  input qmalu_pkg::word_t out_result_value,
  input qmalu_pkg::fill_t out_fill_count,
  input qmalu_pkg::stat_t out_status
);
  import qmalu_pkg::*;

  // a push completes at once
  a_push_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_operation == OP_PUSH) |=> out_strobe)
    else $error("push result not shown in the following cycle");

  // an accepted word is either answered or still in progress
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_strobe))
    else $error("accepted word neither answered nor in progress");

  // leaving busy always delivers the result
  a_busy_end_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_strobe)
    else $error("busy dropped without a result");

  // underflow only with fewer than two entries
  a_under_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status == ST_UNDER) |-> (out_fill_count < 11'd2))
    else $error("underflow reported with two or more entries");

  // errors carry a zero word
  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_status == ST_UNDER || out_status == ST_OVER))
      |-> (out_result_value == '0))
    else $error("error result carries a non-zero word");

endmodule

bind queue_machine_alu_unit qmalu_checker u_qmalu_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .in_operation     (in_operation),
  .out_strobe       (out_strobe),
  .out_result_value (out_result_value),
  .out_fill_count   (out_fill_count),
  .out_status       (out_status)
);
